/* rtl/bezier_curve_sampler_core_assert.svh */
// ----------------------------------------------------------------------------
// Bezier curve sampler assertion macros
// Short forms for the concurrent checks at the end of the core.
// ----------------------------------------------------------------------------
`ifndef BEZIER_CURVE_SAMPLER_CORE_ASSERT_SVH
`define BEZIER_CURVE_SAMPLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define BCS_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BCS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bcs_pkg.sv */
// ----------------------------------------------------------------------------
// Bezier curve sampler package
// Beat types, register indexes and shared constants.
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int MAX_SAMPLES    = 63;
  localparam int FRAC_W         = 16;
  localparam int COORD_W        = 32;
  localparam int SCNT_W         = 6;
  localparam int T_W            = FRAC_W + 1;

  localparam logic [SCNT_W-1:0] SCNT_RESET = 6'd16;

  // register index, taken from paddr[2]
  localparam logic REG_SAMPLE_COUNT = 1'b0;
  localparam logic REG_DERIV_MODE   = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      last_point;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] sample_x;
    logic signed [COORD_W-1:0] sample_y;
    logic signed [COORD_W-1:0] sample_z;
    logic                      last_sample;
    logic                      overflow;
  } out_beat_t;

  typedef struct packed {
    logic start;
    logic adv;
  } tgen_ctl_t;

  typedef struct packed {
    logic           rdy;
    logic [T_W-1:0] t;
  } tgen_sts_t;

endpackage

/* rtl/bezier_curve_sampler_core.sv */
// ----------------------------------------------------------------------------
// Bezier curve sampler core
// Stores 3-D control points and emits de Casteljau samples of the curve or of its derivative.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | beat
//   in_     | in        | in_valid/in_stall  | one control point
//   out_    | out       | out_valid/out_stall| one curve sample
//   apb     | in        | psel/penable/pready| sample_count, derivative_mode
//
// A control point is accepted while the core is idle. The last point opens
// a burst: a 17-step serial divide makes the t step, then each sample runs a
// load pass (cnt reads) and one pass per triangle level (len reads,
// len = n .. 2) over the work memory, then a fetch and an emit. Input holds
// stalled for the whole burst. Reset is synchronous and clears control state
// only; the memories are never cleared. A stalled output beat holds in the
// output register.
//
module bezier_curve_sampler_core #(
  parameter int MAX_POINTS = bcs_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bcs_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bcs_pkg::out_beat_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  `include "bezier_curve_sampler_core_assert.svh"

  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PCW = $clog2(MAX_POINTS + 1);
  localparam int WW  = bcs_pkg::COORD_W + 1 + AW;
  localparam int CW  = AW + 18;
  localparam int CDW = 3 * bcs_pkg::COORD_W;
  localparam int SW  = bcs_pkg::SCNT_W;
  localparam int TW  = bcs_pkg::T_W;

  localparam logic [WW-1:0] SAT_HI = {{(WW-32){1'b0}}, 32'h7fff_ffff};
  localparam logic [WW-1:0] SAT_LO = {{(WW-32){1'b1}}, 32'h8000_0000};

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_TDIV  = 6'b000010,
    ST_ISSUE = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_FETCH = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [SW-1:0] scnt_cfg_r;
  logic          deriv_cfg_r;
  logic          cfg_wr;
  logic [SW-1:0] s_eff;

  // point store bookkeeping
  logic [PCW-1:0] count_r;
  logic           dropped_r;
  logic           full;
  logic           in_acc;
  logic [PCW-1:0] cnt_b;

  // burst state
  logic [PCW-1:0] cnt_r;
  logic [PCW-1:0] n_r;
  logic [SW-1:0]  s_r;
  logic [SW-1:0]  k_r;
  logic           deriv_r;
  logic           drop_r;
  logic           pass_load_r;
  logic [PCW-1:0] lvl_r;
  logic [PCW-1:0] lvl_nxt;
  logic [PCW-1:0] len_rd_r;
  logic [AW-1:0]  rd_idx_r;
  logic           issue_last;
  logic           sample_go;
  logic           emit_go;
  logic           last_k;

  // memories and the read-modify-write pipe
  logic [CDW-1:0]  cmem [MAX_POINTS];
  logic [3*WW-1:0] wmem [MAX_POINTS];
  logic [CDW-1:0]  cq_r;
  logic [3*WW-1:0] wq_r;
  logic [AW-1:0]   raddr;
  logic            rd_vld_r;
  logic [AW-1:0]   idx_d_r;
  logic            v1_r, v2_r;
  logic [AW-1:0]   wa1_r, wa2_r;
  logic            pipe_empty;
  logic            pos_load;
  logic            feed_vld;
  logic [AW-1:0]   feed_addr;
  logic [PCW-1:0]  m_val;
  logic [CW-1:0]   c0, c1;

  logic [2:0][WW-1:0] cur;
  logic [2:0][WW-1:0] prev_r;
  logic [2:0][WW-1:0] lane_a;
  logic [2:0][WW-1:0] lane_res;
  logic [2:0][31:0]   sat_val;
  logic [2:0]         sat_hit;

  // output register
  logic               out_valid_r;
  bcs_pkg::out_beat_t out_data_r;

  bcs_pkg::tgen_ctl_t tg_ctl;
  bcs_pkg::tgen_sts_t tg_sts;

  // --------------------------------------------------------------------------
  // Configuration port: zero-wait writes, registers at 4*index
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scnt_cfg_r  <= bcs_pkg::SCNT_RESET;
      deriv_cfg_r <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        bcs_pkg::REG_SAMPLE_COUNT: scnt_cfg_r  <= pwdata[SW-1:0];
        bcs_pkg::REG_DERIV_MODE:   deriv_cfg_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bcs_pkg::REG_SAMPLE_COUNT: prdata = {{(32-SW){1'b0}}, scnt_cfg_r};
      bcs_pkg::REG_DERIV_MODE:   prdata = {31'b0, deriv_cfg_r};
      default:                   prdata = '0;
    endcase
  end

  // zero counts as one sample; clamp to the sample limit
  always_comb begin
    if (scnt_cfg_r == '0) begin
      s_eff = SW'(1);
    end else if (scnt_cfg_r > SW'(bcs_pkg::MAX_SAMPLES)) begin
      s_eff = SW'(bcs_pkg::MAX_SAMPLES);
    end else begin
      s_eff = scnt_cfg_r;
    end
  end

  // --------------------------------------------------------------------------
  // Point loading
  // --------------------------------------------------------------------------
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (count_r == PCW'(MAX_POINTS));
  assign cnt_b    = full ? count_r : count_r + PCW'(1);

  always_ff @(posedge clk) begin
    if (in_acc && !full) begin
      cmem[count_r[AW-1:0]] <= {in_data.point_z, in_data.point_y, in_data.point_x};
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign pipe_empty = !rd_vld_r && !v1_r && !v2_r;
  assign issue_last = (PCW'(rd_idx_r) == len_rd_r - PCW'(1));
  assign lvl_nxt    = pass_load_r ? n_r : lvl_r - PCW'(1);
  assign last_k     = (k_r == s_r);
  assign emit_go    = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign sample_go  = ((state_r == ST_TDIV) && tg_sts.rdy) || (emit_go && !last_k);

  assign tg_ctl.start = in_acc && in_data.last_point;
  assign tg_ctl.adv   = emit_go && !last_k;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.last_point) state_nxt = ST_TDIV;
      end
      ST_TDIV: begin
        if (tg_sts.rdy) state_nxt = (n_r == '0) ? ST_EMIT : ST_ISSUE;
      end
      ST_ISSUE: begin
        if (issue_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (pipe_empty) state_nxt = (lvl_nxt >= PCW'(2)) ? ST_ISSUE : ST_FETCH;
      end
      ST_FETCH: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) begin
          if (last_k) state_nxt = ST_IDLE;
          else        state_nxt = (n_r == '0) ? ST_EMIT : ST_ISSUE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      pass_load_r <= 1'b1;
      rd_idx_r    <= '0;
      len_rd_r    <= '0;
      lvl_r       <= '0;
      k_r         <= '0;
    end else begin
      state_r <= state_nxt;
      // count points; a point beyond the store is dropped and flagged
      if (in_acc) begin
        if (in_data.last_point) begin
          count_r   <= '0;
          dropped_r <= 1'b0;
          k_r       <= '0;
        end else if (full) begin
          dropped_r <= 1'b1;
        end else begin
          count_r <= count_r + PCW'(1);
        end
      end
      if (sample_go) begin
        pass_load_r <= 1'b1;
        len_rd_r    <= cnt_r;
        rd_idx_r    <= '0;
      end else if (state_r == ST_ISSUE) begin
        rd_idx_r <= rd_idx_r + AW'(1);
      end else if ((state_r == ST_DRAIN) && pipe_empty) begin
        // from here on the finished w0 comes from the work memory
        pass_load_r <= 1'b0;
        lvl_r       <= lvl_nxt;
        len_rd_r    <= lvl_nxt;
        rd_idx_r    <= '0;
      end
      if (emit_go && !last_k) begin
        k_r <= k_r + SW'(1);
      end
    end
  end

  // latch the curve description when the last point arrives
  always_ff @(posedge clk) begin
    if (in_acc && in_data.last_point) begin
      cnt_r   <= cnt_b;
      n_r     <= deriv_cfg_r ? cnt_b - PCW'(1) : cnt_b;
      s_r     <= s_eff;
      deriv_r <= deriv_cfg_r;
      drop_r  <= dropped_r || full;
    end
  end

  bcs_tgen u_tgen (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (tg_ctl),
    .s     (s_eff),
    .sts   (tg_sts)
  );

  // --------------------------------------------------------------------------
  // Memory reads: one address a cycle, data registered
  // --------------------------------------------------------------------------
  assign raddr = (state_r == ST_ISSUE) ? rd_idx_r : '0;

  always_ff @(posedge clk) begin
    cq_r    <= cmem[raddr];
    wq_r    <= wmem[raddr];
    idx_d_r <= rd_idx_r;
  end

  // --------------------------------------------------------------------------
  // Interpolation feed. A load pass copies points (position) or forms the
  // scaled differences (derivative); a level pass blends neighbours. All go
  // through the same lanes, only the coefficients change.
  // --------------------------------------------------------------------------
  assign pos_load  = pass_load_r && !deriv_r;
  assign feed_vld  = rd_vld_r && (pos_load || (idx_d_r != '0));
  assign feed_addr = pos_load ? idx_d_r : idx_d_r - AW'(1);
  assign m_val     = cnt_r - PCW'(1);

  always_comb begin
    if (pos_load) begin
      c0 = CW'(1 << bcs_pkg::FRAC_W);
      c1 = '0;
    end else if (pass_load_r) begin
      c1 = CW'({m_val, {bcs_pkg::FRAC_W{1'b0}}});
      c0 = CW'(0) - c1;
    end else begin
      c0 = CW'(TW'(1 << bcs_pkg::FRAC_W) - tg_sts.t);
      c1 = CW'(tg_sts.t);
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    always_comb begin
      if (pass_load_r) begin
        cur[l] = WW'($signed(cq_r[l*32 +: 32]));
      end else begin
        cur[l] = wq_r[l*WW +: WW];
      end
      lane_a[l] = pos_load ? cur[l] : prev_r[l];
    end

    always_ff @(posedge clk) begin
      if (rd_vld_r) begin
        prev_r[l] <= cur[l];
      end
    end

    bcs_lerp #(
      .WW (WW),
      .CW (CW)
    ) u_lerp (
      .clk (clk),
      .a   (lane_a[l]),
      .b   (cur[l]),
      .c0  (c0),
      .c1  (c1),
      .res (lane_res[l])
    );

    // saturate the finished coordinate held at the read port
    always_comb begin
      sat_hit[l] = 1'b0;
      sat_val[l] = cur[l][31:0];
      if ($signed(cur[l]) > $signed(SAT_HI)) begin
        sat_hit[l] = 1'b1;
        sat_val[l] = SAT_HI[31:0];
      end else if ($signed(cur[l]) < $signed(SAT_LO)) begin
        sat_hit[l] = 1'b1;
        sat_val[l] = SAT_LO[31:0];
      end
    end
  end

  // pipe valids alongside the lane registers; write back at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == ST_ISSUE);
      v1_r     <= feed_vld;
      v2_r     <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    wa1_r <= feed_addr;
    wa2_r <= wa1_r;
    if (v2_r) begin
      wmem[wa2_r] <= {lane_res[2], lane_res[1], lane_res[0]};
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // a single point in derivative mode gives samples of value zero
  always_ff @(posedge clk) begin
    if (emit_go) begin
      if (n_r == '0) begin
        out_data_r.sample_x <= '0;
        out_data_r.sample_y <= '0;
        out_data_r.sample_z <= '0;
        out_data_r.overflow <= drop_r;
      end else begin
        out_data_r.sample_x <= sat_val[0];
        out_data_r.sample_y <= sat_val[1];
        out_data_r.sample_z <= sat_val[2];
        out_data_r.overflow <= drop_r || (|sat_hit);
      end
      out_data_r.last_sample <= last_k;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `BCS_ASSERT_NOW(a_no_wb_at_fetch, clk, rst_n, v2_r, !((state_r == ST_FETCH) || (state_r == ST_EMIT)), "write-back overlaps fetch of w0")
  `BCS_ASSERT_NOW(a_rd_in_range, clk, rst_n, (state_r == ST_ISSUE), (PCW'(rd_idx_r) < len_rd_r), "read index beyond pass length")
  `BCS_ASSERT_NOW(a_t_ready, clk, rst_n, (state_r == ST_ISSUE), tg_sts.rdy, "pass issued while t divide runs")
  `BCS_ASSERT_NEXT(a_last_to_idle, clk, rst_n, (emit_go && last_k), (state_r == ST_IDLE), "burst did not end on last sample")

endmodule

/* rtl/bcs_lerp.sv */
// ----------------------------------------------------------------------------
// Bezier curve sampler interpolation lane
// Two-stage a*c0 + b*c1 with round to nearest at 16 fraction bits.
// ----------------------------------------------------------------------------
module bcs_lerp #(
  parameter int WW = 37,
  parameter int CW = 22
) (
  input  logic          clk,
  input  logic [WW-1:0] a,
  input  logic [WW-1:0] b,
  input  logic [CW-1:0] c0,
  input  logic [CW-1:0] c1,
  output logic [WW-1:0] res
);

  localparam int PW = WW + CW;
  localparam int SW = PW + 1;

  logic signed [PW-1:0] p0_r;
  logic signed [PW-1:0] p1_r;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] sum_sh;
  logic [WW-1:0]        res_r;

  always_ff @(posedge clk) begin
    p0_r <= $signed(a) * $signed(c0);
    p1_r <= $signed(b) * $signed(c1);
  end

  // floor((p0 + p1 + half) / 2^16) gives ties toward plus infinity
  always_comb begin
    sum    = {p0_r[PW-1], p0_r} + {p1_r[PW-1], p1_r}
             + SW'(1 << (bcs_pkg::FRAC_W - 1));
    sum_sh = sum >>> bcs_pkg::FRAC_W;
  end

  always_ff @(posedge clk) begin
    res_r <= sum_sh[WW-1:0];
  end

  assign res = res_r;

endmodule

/* rtl/bcs_tgen.sv */
// ----------------------------------------------------------------------------
// Bezier curve sampler parameter generator
// Serial divide of 1.0 by the sample count, then t = floor(k * 2^16 / S) stepping.
// ----------------------------------------------------------------------------
module bcs_tgen (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bcs_pkg::tgen_ctl_t              ctl,
  input  logic [bcs_pkg::SCNT_W-1:0]      s,
  output bcs_pkg::tgen_sts_t              sts
);

  localparam int SW = bcs_pkg::SCNT_W;
  localparam int TW = bcs_pkg::T_W;

  logic          busy_r;
  logic [4:0]    cnt_r;
  logic [SW-1:0] s_r;
  logic [SW-1:0] rem_r;
  logic [TW-1:0] q_r;
  logic [SW-1:0] racc_r;
  logic [TW-1:0] t_r;
  logic [SW:0]   trial;
  logic          qbit;
  logic [SW:0]   racc_sum;
  logic          racc_wrap;

  // restoring step: the dividend is 1 followed by sixteen zeros
  always_comb begin
    trial     = {rem_r, (cnt_r == 5'd0)};
    qbit      = (trial >= {1'b0, s_r});
    racc_sum  = {1'b0, racc_r} + {1'b0, rem_r};
    racc_wrap = (racc_sum >= {1'b0, s_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'(TW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      s_r    <= s;
      rem_r  <= '0;
      q_r    <= '0;
      racc_r <= '0;
      t_r    <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? SW'(trial - {1'b0, s_r}) : trial[SW-1:0];
      q_r   <= {q_r[TW-2:0], qbit};
    end else if (ctl.adv) begin
      if (racc_wrap) begin
        racc_r <= SW'(racc_sum - {1'b0, s_r});
        t_r    <= t_r + q_r + TW'(1);
      end else begin
        racc_r <= racc_sum[SW-1:0];
        t_r    <= t_r + q_r;
      end
    end
  end

  assign sts.rdy = !busy_r;
  assign sts.t   = t_r;

endmodule
